// ----- hdl/nsbmd_pkg.sv -----
// shared types, constants and float helpers for the block mean downsampler
`default_nettype none
package nsbmd_pkg;

   localparam int MAX_DIM_DEF     = 1024;
   localparam int MAX_FACTOR_DEF  = 16;
   localparam int ACC_ENTRIES_DEF = 4096;

   localparam int VOX_W      = 32;
   localparam int BLK_W      = 10;
   localparam int CNT_W      = 13;
   localparam int DIM_REG_W  = 11;
   localparam int FAC_REG_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_DIM_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_Z = 3'd5;

   localparam logic [DIM_REG_W-1:0] DIM_RESET    = 11'd1024;
   localparam logic [FAC_REG_W-1:0] FACTOR_RESET = 5'd2;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;

   typedef struct packed {
      logic setup_step;
      logic ovf_calc;
      logic load;
      logic upd_first;
      logic upd_keep;
      logic add_align;
      logic norm_step;
      logic add_round;
      logic mem_wr;
      logic set_nan;
      logic div_init;
      logic dnorm_step;
      logic div_start;
      logic div_step;
      logic div_round;
      logic out_load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic cfg_hit;
      logic setup_done;
      logic ovf;
      logic first;
      logic blank;
      logic last;
      logic norm_done;
      logic dnorm_done;
      logic div_done;
      logic cnt_zero;
      logic out_free;
   } sts_type;

   function automatic logic is_nan(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   // round to nearest even and pack; mant_in[26] is the leading bit position,
   // mant_in[2] guard, mant_in[1:0] sticky; exponents below one are denormalised
   function automatic logic [31:0] fp_round(input logic sign,
                                            input logic signed [10:0] exp_in,
                                            input logic [26:0] mant_in);
      logic signed [10:0] e;
      logic [26:0] r;
      logic [10:0] sh;
      logic [26:0] mask;
      logic lost;
      logic [23:0] m;
      logic up;
      logic [24:0] m25;
      logic [31:0] res;
      e    = exp_in;
      r    = mant_in;
      lost = 1'b0;
      sh   = '0;
      mask = '0;
      if (e < 11'sd1) begin
         sh = 11'(11'sd1 - e);
         if (sh >= 11'd27) begin
            lost = |r;
            r    = '0;
         end else begin
            mask = (27'd1 << sh[4:0]) - 27'd1;
            lost = |(r & mask);
            r    = r >> sh[4:0];
         end
         r[0] = r[0] | lost;
         e    = 11'sd1;
      end
      m   = r[26:3];
      up  = r[2] & (r[1] | r[0] | m[0]);
      m25 = {1'b0, m} + 25'(up);
      if (m25[24]) begin
         m = m25[24:1];
         e = e + 11'sd1;
      end else begin
         m = m25[23:0];
      end
      if (e >= 11'sd255) begin
         res = {sign, 8'hFF, 23'd0};
      end else begin
         res = {sign, (m[23] ? e[7:0] : 8'd0), m[22:0]};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/nsbmd_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module nsbmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hdl/nsbmd_ctrl.sv -----
// sequencing state machine for the block mean downsampler
`default_nettype none
module nsbmd_ctrl
   import nsbmd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire sts_type sts,
   input  wire logic req_valid,
   output logic req_ready,
   output cmd_type cmd
);

   localparam logic [3:0] S_SETUP  = 4'd0;
   localparam logic [3:0] S_OVF    = 4'd1;
   localparam logic [3:0] S_IDLE   = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_NORM   = 4'd4;
   localparam logic [3:0] S_ROUND  = 4'd5;
   localparam logic [3:0] S_WRITE  = 4'd6;
   localparam logic [3:0] S_CHECK  = 4'd7;
   localparam logic [3:0] S_DNORM  = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_DROUND = 4'd10;
   localparam logic [3:0] S_FINISH = 4'd11;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_SETUP: begin
            cmd.setup_step = 1'b1;
            if (sts.setup_done) begin
               state_in = S_OVF;
            end
         end
         S_OVF: begin
            cmd.ovf_calc = 1'b1;
            state_in     = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (sts.ovf) begin
               cmd.set_nan = 1'b1;
               state_in    = S_FINISH;
            end else if (sts.first) begin
               cmd.upd_first = 1'b1;
               state_in      = S_WRITE;
            end else if (sts.blank) begin
               cmd.upd_keep = 1'b1;
               state_in     = S_CHECK;
            end else begin
               cmd.add_align = 1'b1;
               state_in      = S_NORM;
            end
         end
         S_NORM: begin
            if (sts.norm_done) begin
               state_in = S_ROUND;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         S_ROUND: begin
            cmd.add_round = 1'b1;
            state_in      = S_WRITE;
         end
         S_WRITE: begin
            cmd.mem_wr = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.last) begin
               state_in = S_FINISH;
            end else if (sts.cnt_zero) begin
               cmd.set_nan = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DNORM;
            end
         end
         S_DNORM: begin
            if (sts.dnorm_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.dnorm_step = 1'b1;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DROUND;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DROUND: begin
            cmd.div_round = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.last) begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end else if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.advance  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_SETUP;
         end
      endcase
      if (sts.cfg_hit) begin
         state_in = S_SETUP;
         cmd      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SETUP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/nsbmd_dp.sv -----
// datapath: registers, raster position, accumulator store, float add and divide
`default_nettype none
module nsbmd_dp
   import nsbmd_pkg::*;
#(
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int MAX_FACTOR  = MAX_FACTOR_DEF,
   parameter int ACC_ENTRIES = ACC_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [VOX_W-1:0]      req_voxel_bits,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [VOX_W-1:0]           rsp_mean_bits,
   output logic [BLK_W-1:0]           rsp_block_x,
   output logic [BLK_W-1:0]           rsp_block_y,
   output logic [BLK_W-1:0]           rsp_block_z,
   output logic                       rsp_cube_done,
   output logic                       rsp_store_overflow
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int FW = $clog2(MAX_FACTOR + 1);
   localparam int OW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int SW = $clog2(MAX_DIM + MAX_FACTOR + 1);
   localparam int AW = (ACC_ENTRIES > 1) ? $clog2(ACC_ENTRIES) : 1;
   localparam int QW0 = (2 * DW > $clog2(ACC_ENTRIES + 1)) ? 2 * DW : $clog2(ACC_ENTRIES + 1);
   localparam int QW = QW0 + 1;
   localparam int MW = VOX_W + CNT_W;

   // configuration
   logic [DIM_REG_W-1:0] dimx_ff, dimx_in, dimy_ff, dimy_in, dimz_ff, dimz_in;
   logic [FAC_REG_W-1:0] facx_ff, facx_in, facy_ff, facy_in, facz_ff, facz_in;
   logic [DW-1:0] dx, dy, dz;
   logic [FW-1:0] fx, fy, fz;
   logic cfg_hit;

   // block counts per row and column
   logic [SW-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic [DW-1:0] nbx_ff, nbx_in, nby_ff, nby_in;
   logic ovf_ff, ovf_in;
   logic [QW-1:0] prod;

   // raster position
   logic [PW-1:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [OW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [PW-1:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic [AW-1:0] rowb_ff, rowb_in;
   logic [FW-1:0] ox_inc, oy_inc, oz_inc;
   logic xe, ye, ze, first, last, done;
   logic [AW-1:0] idx;

   // accumulator and adder
   logic [VOX_W-1:0] voxel_ff, voxel_in;
   logic [VOX_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] rd_data;
   logic [VOX_W-1:0] rd_sum;
   logic [CNT_W-1:0] rd_cnt;
   logic [27:0] ar_ff, ar_in;
   logic [9:0] ae_ff, ae_in;
   logic as_ff, as_in, aspec_ff, aspec_in;
   logic [31:0] aspec_val_ff, aspec_val_in;
   logic [31:0] big, sml;
   logic [7:0] eb, es, d;
   logic [23:0] mb, ms;
   logic [26:0] ext, shv, amask;
   logic [27:0] r_al;
   logic a_inf, b_inf;

   // divider
   logic [23:0] dm_ff, dm_in;
   logic signed [10:0] de_ff, de_in;
   logic [CNT_W-1:0] dc_ff, dc_in;
   logic [3:0] dk_ff, dk_in;
   logic [24:0] drem_ff, drem_in;
   logic [26:0] dq_ff, dq_in;
   logic [4:0] dn_ff, dn_in;
   logic dsign_ff, dsign_in, dspec_ff, dspec_in;
   logic [31:0] dspec_val_ff, dspec_val_in;
   logic [24:0] dvsr;
   logic dge;
   logic signed [10:0] dexp;
   logic [26:0] dmant;
   logic [31:0] dres;
   logic [31:0] mean_ff, mean_in;

   // result beat
   logic rsp_valid_ff, rsp_valid_in;
   logic [VOX_W-1:0] rsp_mean_ff;
   logic [BLK_W-1:0] rsp_bx_ff, rsp_by_ff, rsp_bz_ff;
   logic rsp_done_ff, rsp_ovf_ff;

   assign cfg_hit = csr_valid && (csr_index <= REG_FACTOR_Z);

   always_comb begin
      dx = (dimx_ff == '0) ? DW'(1) : ((32'(dimx_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dimx_ff));
      dy = (dimy_ff == '0) ? DW'(1) : ((32'(dimy_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dimy_ff));
      dz = (dimz_ff == '0) ? DW'(1) : ((32'(dimz_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dimz_ff));
      fx = (facx_ff == '0) ? FW'(1) :
           ((32'(facx_ff) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(facx_ff));
      fy = (facy_ff == '0) ? FW'(1) :
           ((32'(facy_ff) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(facy_ff));
      fz = (facz_ff == '0) ? FW'(1) :
           ((32'(facz_ff) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(facz_ff));
   end

   always_comb begin
      ox_inc = FW'(ox_ff) + FW'(1);
      oy_inc = FW'(oy_ff) + FW'(1);
      oz_inc = FW'(oz_ff) + FW'(1);
      xe     = (DW'(vx_ff) == dx - DW'(1));
      ye     = (DW'(vy_ff) == dy - DW'(1));
      ze     = (DW'(vz_ff) == dz - DW'(1));
      first  = (ox_ff == '0) && (oy_ff == '0) && (oz_ff == '0);
      last   = (ox_inc == fx || xe) && (oy_inc == fy || ye) && (oz_inc == fz || ze);
      done   = xe && ye && ze;
      idx    = rowb_ff + AW'(bx_ff);
      prod   = QW'(nbx_ff) * QW'(nby_ff);
   end

   nsbmd_ram #(
      .WIDTH (MW),
      .DEPTH (ACC_ENTRIES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (idx),
      .wr_data ({sum_ff, cnt_ff}),
      .rd_en   (cmd.load),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   assign rd_sum = rd_data[MW-1:CNT_W];
   assign rd_cnt = rd_data[CNT_W-1:0];

   // alignment of the smaller operand and magnitude add or subtract
   always_comb begin
      a_inf = (rd_sum[30:23] == 8'hFF) && (rd_sum[22:0] == 23'd0);
      b_inf = (voxel_ff[30:23] == 8'hFF) && (voxel_ff[22:0] == 23'd0);
      if (voxel_ff[30:0] > rd_sum[30:0]) begin
         big = voxel_ff;
         sml = rd_sum;
      end else begin
         big = rd_sum;
         sml = voxel_ff;
      end
      eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d     = eb - es;
      mb    = {big[30:23] != 8'd0, big[22:0]};
      ms    = {sml[30:23] != 8'd0, sml[22:0]};
      ext   = {ms, 3'b000};
      amask = '0;
      if (d >= 8'd27) begin
         shv = {26'd0, |ms};
      end else begin
         amask  = (27'd1 << d[4:0]) - 27'd1;
         shv    = ext >> d[4:0];
         shv[0] = shv[0] | (|(ext & amask));
      end
      if (rd_sum[31] == voxel_ff[31]) begin
         r_al = {1'b0, mb, 3'b000} + {1'b0, shv};
      end else begin
         r_al = {1'b0, mb, 3'b000} - {1'b0, shv};
      end
   end

   // quotient digit and rounded quotient
   always_comb begin
      dvsr  = {1'b0, dc_ff, 11'd0};
      dge   = (drem_ff >= dvsr);
      if (dq_ff[26]) begin
         dexp  = de_ff - $signed({7'd0, dk_ff});
         dmant = {dq_ff[26:1], dq_ff[0] | (drem_ff != '0)};
      end else begin
         dexp  = de_ff - $signed({7'd0, dk_ff}) - 11'sd1;
         dmant = {dq_ff[25:0], drem_ff != '0};
      end
      dres = dspec_ff ? dspec_val_ff : fp_round(dsign_ff, dexp, dmant);
   end

   always_comb begin
      dimx_in = dimx_ff; dimy_in = dimy_ff; dimz_in = dimz_ff;
      facx_in = facx_ff; facy_in = facy_ff; facz_in = facz_ff;
      accx_in = accx_ff; accy_in = accy_ff;
      nbx_in  = nbx_ff;  nby_in  = nby_ff;
      ovf_in  = ovf_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      rowb_in = rowb_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.setup_step) begin
         if (accx_ff < SW'(dx)) begin
            accx_in = accx_ff + SW'(fx);
            nbx_in  = nbx_ff + DW'(1);
         end
         if (accy_ff < SW'(dy)) begin
            accy_in = accy_ff + SW'(fy);
            nby_in  = nby_ff + DW'(1);
         end
      end
      if (cmd.ovf_calc) begin
         ovf_in = (prod > QW'(ACC_ENTRIES));
      end

      if (cmd.advance) begin
         if (xe) begin
            vx_in = '0; ox_in = '0; bx_in = '0;
            if (ye) begin
               vy_in = '0; oy_in = '0; by_in = '0; rowb_in = '0;
               if (ze) begin
                  vz_in = '0; oz_in = '0; bz_in = '0;
               end else begin
                  vz_in = vz_ff + PW'(1);
                  if (oz_inc >= fz) begin
                     oz_in = '0;
                     bz_in = bz_ff + PW'(1);
                  end else begin
                     oz_in = OW'(oz_inc);
                  end
               end
            end else begin
               vy_in = vy_ff + PW'(1);
               if (oy_inc >= fy) begin
                  oy_in   = '0;
                  by_in   = by_ff + PW'(1);
                  rowb_in = rowb_ff + AW'(nbx_ff);
               end else begin
                  oy_in = OW'(oy_inc);
               end
            end
         end else begin
            vx_in = vx_ff + PW'(1);
            if (ox_inc >= fx) begin
               ox_in = '0;
               bx_in = bx_ff + PW'(1);
            end else begin
               ox_in = OW'(ox_inc);
            end
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cfg_hit) begin
         case (csr_index)
            REG_DIM_X:    dimx_in = csr_wdata;
            REG_DIM_Y:    dimy_in = csr_wdata;
            REG_DIM_Z:    dimz_in = csr_wdata;
            REG_FACTOR_X: facx_in = csr_wdata[FAC_REG_W-1:0];
            REG_FACTOR_Y: facy_in = csr_wdata[FAC_REG_W-1:0];
            REG_FACTOR_Z: facz_in = csr_wdata[FAC_REG_W-1:0];
            default: ;
         endcase
         accx_in = '0; accy_in = '0; nbx_in = '0; nby_in = '0;
         vx_in = '0; vy_in = '0; vz_in = '0;
         ox_in = '0; oy_in = '0; oz_in = '0;
         bx_in = '0; by_in = '0; bz_in = '0;
         rowb_in = '0;
      end
   end

   always_comb begin
      voxel_in     = voxel_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      ar_in        = ar_ff;
      ae_in        = ae_ff;
      as_in        = as_ff;
      aspec_in     = aspec_ff;
      aspec_val_in = aspec_val_ff;
      dm_in = dm_ff; de_in = de_ff; dc_in = dc_ff; dk_in = dk_ff;
      drem_in = drem_ff; dq_in = dq_ff; dn_in = dn_ff;
      dsign_in = dsign_ff; dspec_in = dspec_ff; dspec_val_in = dspec_val_ff;
      mean_in = mean_ff;

      if (cmd.load) begin
         voxel_in = req_voxel_bits;
      end
      if (cmd.upd_first) begin
         if (is_nan(voxel_ff)) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = (voxel_ff == NEG_ZERO) ? '0 : voxel_ff;
            cnt_in = CNT_W'(1);
         end
      end
      if (cmd.upd_keep) begin
         sum_in = rd_sum;
         cnt_in = rd_cnt;
      end
      if (cmd.add_align) begin
         cnt_in       = rd_cnt + CNT_W'(1);
         ar_in        = r_al;
         ae_in        = {2'b00, eb};
         as_in        = (r_al == '0) ? (rd_sum[31] & voxel_ff[31]) : big[31];
         aspec_in     = 1'b0;
         aspec_val_in = QNAN_BITS;
         if (is_nan(rd_sum)) begin
            aspec_in = 1'b1;
         end else if (a_inf || b_inf) begin
            aspec_in = 1'b1;
            if (a_inf && b_inf && (rd_sum[31] != voxel_ff[31])) begin
               aspec_val_in = QNAN_BITS;
            end else if (a_inf) begin
               aspec_val_in = rd_sum;
            end else begin
               aspec_val_in = voxel_ff;
            end
         end
      end
      if (cmd.norm_step) begin
         if (ar_ff[27]) begin
            ar_in = {1'b0, ar_ff[27:2], ar_ff[1] | ar_ff[0]};
            ae_in = ae_ff + 10'd1;
         end else begin
            ar_in = {ar_ff[26:0], 1'b0};
            ae_in = ae_ff - 10'd1;
         end
      end
      if (cmd.add_round) begin
         sum_in = aspec_ff ? aspec_val_ff : fp_round(as_ff, $signed({1'b0, ae_ff}), ar_ff[26:0]);
      end

      if (cmd.div_init) begin
         dsign_in     = sum_ff[31];
         dm_in        = {sum_ff[30:23] != 8'd0, sum_ff[22:0]};
         de_in        = $signed({3'b000, (sum_ff[30:23] == 8'd0) ? 8'd1 : sum_ff[30:23]});
         dc_in        = cnt_ff;
         dk_in        = 4'd12;
         dspec_in     = 1'b0;
         dspec_val_in = QNAN_BITS;
         if (sum_ff[30:23] == 8'hFF) begin
            dspec_in     = 1'b1;
            dspec_val_in = (sum_ff[22:0] != 23'd0) ? QNAN_BITS : {sum_ff[31], 8'hFF, 23'd0};
         end else if (sum_ff[30:0] == 31'd0) begin
            dspec_in     = 1'b1;
            dspec_val_in = {sum_ff[31], 31'd0};
         end
      end
      if (cmd.dnorm_step) begin
         if (!dm_ff[23]) begin
            dm_in = {dm_ff[22:0], 1'b0};
            de_in = de_ff - 11'sd1;
         end
         if (!dc_ff[CNT_W-1]) begin
            dc_in = {dc_ff[CNT_W-2:0], 1'b0};
            dk_in = dk_ff - 4'd1;
         end
      end
      if (cmd.div_start) begin
         drem_in = {1'b0, dm_ff};
         dq_in   = '0;
         dn_in   = '0;
      end
      if (cmd.div_step) begin
         dq_in   = {dq_ff[25:0], dge};
         drem_in = dge ? ((drem_ff - dvsr) << 1) : (drem_ff << 1);
         dn_in   = dn_ff + 5'd1;
      end
      if (cmd.set_nan) begin
         mean_in = QNAN_BITS;
      end
      if (cmd.div_round) begin
         mean_in = is_nan(dres) ? QNAN_BITS : dres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dimx_ff <= DIM_RESET; dimy_ff <= DIM_RESET; dimz_ff <= DIM_RESET;
         facx_ff <= FACTOR_RESET; facy_ff <= FACTOR_RESET; facz_ff <= FACTOR_RESET;
         accx_ff <= '0; accy_ff <= '0; nbx_ff <= '0; nby_ff <= '0;
         ovf_ff  <= 1'b0;
         vx_ff <= '0; vy_ff <= '0; vz_ff <= '0;
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         bx_ff <= '0; by_ff <= '0; bz_ff <= '0;
         rowb_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dimx_ff <= dimx_in; dimy_ff <= dimy_in; dimz_ff <= dimz_in;
         facx_ff <= facx_in; facy_ff <= facy_in; facz_ff <= facz_in;
         accx_ff <= accx_in; accy_ff <= accy_in; nbx_ff <= nbx_in; nby_ff <= nby_in;
         ovf_ff  <= ovf_in;
         vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
         ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
         bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
         rowb_ff <= rowb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      voxel_ff     <= voxel_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      ar_ff        <= ar_in;
      ae_ff        <= ae_in;
      as_ff        <= as_in;
      aspec_ff     <= aspec_in;
      aspec_val_ff <= aspec_val_in;
      dm_ff <= dm_in; de_ff <= de_in; dc_ff <= dc_in; dk_ff <= dk_in;
      drem_ff <= drem_in; dq_ff <= dq_in; dn_ff <= dn_in;
      dsign_ff <= dsign_in; dspec_ff <= dspec_in; dspec_val_ff <= dspec_val_in;
      mean_ff <= mean_in;
      if (cmd.out_load) begin
         rsp_mean_ff <= mean_ff;
         rsp_bx_ff   <= BLK_W'(bx_ff);
         rsp_by_ff   <= BLK_W'(by_ff);
         rsp_bz_ff   <= BLK_W'(bz_ff);
         rsp_done_ff <= done;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   always_comb begin
      sts.cfg_hit    = cfg_hit;
      sts.setup_done = (accx_ff >= SW'(dx)) && (accy_ff >= SW'(dy));
      sts.ovf        = ovf_ff;
      sts.first      = first;
      sts.blank      = is_nan(voxel_ff);
      sts.last       = last;
      sts.norm_done  = aspec_ff || (!ar_ff[27] && (ar_ff[26] || ae_ff <= 10'd1 || ar_ff == '0));
      sts.dnorm_done = dspec_ff || (dm_ff[23] && dc_ff[CNT_W-1]);
      sts.div_done   = (dn_ff == 5'd27);
      sts.cnt_zero   = (cnt_ff == '0);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_bits      = rsp_mean_ff;
   assign rsp_block_x        = rsp_bx_ff;
   assign rsp_block_y        = rsp_by_ff;
   assign rsp_block_z        = rsp_bz_ff;
   assign rsp_cube_done      = rsp_done_ff;
   assign rsp_store_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

// ----- hdl/nan_skipping_block_mean_downsample_unit.sv -----
// top level of the nan skipping block mean downsampler
`default_nettype none
// Voxels arrive in raster order (x fastest) and are reduced to the float32 mean of the non-NaN
// voxels of each block, one result beat at each block's last voxel. One voxel is in flight at
// a time: a voxel passes through the accumulator read, float add and write back, plus
// normalisation one bit at a time after cancellation. A block's last voxel adds the divide:
// operand normalisation, quotient bits one at a time and a round. After reset and after
// every write to a size or factor register the block sizes the plane of blocks by repeated
// addition before it takes voxels. The result register lets the next voxel enter while a
// result beat waits.
module nan_skipping_block_mean_downsample_unit
   import nsbmd_pkg::*;
#(
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int MAX_FACTOR  = MAX_FACTOR_DEF,
   parameter int ACC_ENTRIES = ACC_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [VOX_W-1:0]      req_voxel_bits,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [VOX_W-1:0]           rsp_mean_bits,
   output logic [BLK_W-1:0]           rsp_block_x,
   output logic [BLK_W-1:0]           rsp_block_y,
   output logic [BLK_W-1:0]           rsp_block_z,
   output logic                       rsp_cube_done,
   output logic                       rsp_store_overflow
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   nsbmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   nsbmd_dp #(
      .MAX_DIM     (MAX_DIM),
      .MAX_FACTOR  (MAX_FACTOR),
      .ACC_ENTRIES (ACC_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_voxel_bits     (req_voxel_bits),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_mean_bits      (rsp_mean_bits),
      .rsp_block_x        (rsp_block_x),
      .rsp_block_y        (rsp_block_y),
      .rsp_block_z        (rsp_block_z),
      .rsp_cube_done      (rsp_cube_done),
      .rsp_store_overflow (rsp_store_overflow)
   );

`ifndef NO_ASSERTIONS
   // an overflowed store never yields a real mean
   a_ovf_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_overflow |-> rsp_mean_bits == QNAN_BITS)
      else $error("overflow beat carries a mean");

   // one voxel at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second voxel taken while one is in work");

   // a write to a size or factor register restarts the sizing pass before voxels are taken
   a_cfg_setup: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index <= REG_FACTOR_Z) |=> !req_ready)
      else $error("voxel taken straight after a register write");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_nan_skipping_block_mean_downsample_unit.sv -----
// self-checking testbench for the nan skipping block mean downsampler
`timescale 1ns / 1ps
module tb_nan_skipping_block_mean_downsample_unit;
   import nsbmd_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int VOXEL_GOAL = 1600;

   typedef struct {
      logic [31:0] mean;
      logic [9:0]  bx;
      logic [9:0]  by;
      logic [9:0]  bz;
      logic        done;
      logic        ovf;
   } block_mean_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [VOX_W-1:0] req_voxel_bits = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [VOX_W-1:0] rsp_mean_bits;
   logic [BLK_W-1:0] rsp_block_x, rsp_block_y, rsp_block_z;
   logic rsp_cube_done, rsp_store_overflow;

   nan_skipping_block_mean_downsample_unit dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_voxel_bits(req_voxel_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_mean_bits(rsp_mean_bits),
      .rsp_block_x(rsp_block_x), .rsp_block_y(rsp_block_y), .rsp_block_z(rsp_block_z),
      .rsp_cube_done(rsp_cube_done), .rsp_store_overflow(rsp_store_overflow)
   );

   always #6 clock = ~clock;

   logic [31:0] voxel_q[$];
   block_mean_type mean_q[$];
   int errors = 0;
   int cycles = 0;
   int pushed = 0;

   // predictor state
   int unsigned cfg_dim[3];
   int unsigned cfg_fac[3];
   int unsigned pos_v[3];
   int unsigned pos_o[3];
   logic [31:0] acc_sum[STORE_DEPTH];
   logic [12:0] acc_cnt[STORE_DEPTH];

   function automatic real to_real(input logic [31:0] f);
      real r;
      if (f[30:23] == 8'd0 && f[22:0] != 23'd0) begin
         r = real'(f[22:0]) * (2.0 ** -149);
         return f[31] ? -r : r;
      end
      if (f[30:23] == 8'd0) return $bitstoreal({f[31], 63'd0});
      if (f[30:23] == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
      return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0});
   endfunction

   function automatic logic [31:0] to_single(input real r);
      logic [63:0] d, sig, kept, rem, half;
      logic s;
      int fe, sh;
      d = $realtobits(r);
      s = d[63];
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN_BITS : {s, 8'hFF, 23'd0};
      if (d[62:0] == 0) return {s, 31'd0};
      sig = {11'd0, 1'b1, d[51:0]};
      fe = int'(d[62:52]) - 1023 + 127;
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 63) sh = 63;
      kept = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      if (fe >= 1) begin
         if (kept[24]) begin
            kept = kept >> 1;
            fe++;
         end
         if (fe >= 255) return {s, 8'hFF, 23'd0};
         return {s, fe[7:0], kept[22:0]};
      end
      return {s, kept[30:0]};
   endfunction

   function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic bit nan_bits(input logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 23'd0;
   endfunction

   function automatic void restart_cube();
      for (int a = 0; a < 3; a++) begin
         pos_v[a] = 0;
         pos_o[a] = 0;
      end
   endfunction

   function automatic void accumulate_voxel(input logic [31:0] vb);
      int unsigned d[3], f[3], b[3], nbx, nby, idx;
      bit ovf, first, last, done, blank;
      block_mean_type e;
      for (int a = 0; a < 3; a++) begin
         d[a] = clamp_cfg(cfg_dim[a], 1024);
         f[a] = clamp_cfg(cfg_fac[a], 16);
         b[a] = pos_v[a] / f[a];
      end
      nbx = (d[0] + f[0] - 1) / f[0];
      nby = (d[1] + f[1] - 1) / f[1];
      ovf = nbx * nby > STORE_DEPTH;
      first = pos_o[0] == 0 && pos_o[1] == 0 && pos_o[2] == 0;
      last = 1'b1;
      done = 1'b1;
      for (int a = 0; a < 3; a++) begin
         last &= (pos_o[a] == f[a] - 1) || (pos_v[a] == d[a] - 1);
         done &= pos_v[a] == d[a] - 1;
      end
      e.mean = QNAN_BITS;
      if (!ovf) begin
         idx = (b[0] + b[1] * nbx) % STORE_DEPTH;
         blank = nan_bits(vb);
         if (first) begin
            acc_sum[idx] = blank ? 32'd0 : to_single(0.0 + to_real(vb));
            acc_cnt[idx] = blank ? 13'd0 : 13'd1;
         end else if (!blank) begin
            acc_sum[idx] = to_single(to_real(acc_sum[idx]) + to_real(vb));
            acc_cnt[idx] = acc_cnt[idx] + 13'd1;
         end
         if (last && acc_cnt[idx] != 0) begin
            e.mean = to_single(to_real(acc_sum[idx]) / real'(acc_cnt[idx]));
            if (nan_bits(e.mean)) e.mean = QNAN_BITS;
         end
      end
      if (last) begin
         e.bx = b[0][9:0];
         e.by = b[1][9:0];
         e.bz = b[2][9:0];
         e.done = done;
         e.ovf = ovf;
         mean_q.push_back(e);
      end
      for (int a = 0; a < 3; a++) begin
         pos_v[a]++;
         pos_o[a]++;
         if (pos_o[a] >= f[a]) pos_o[a] = 0;
         if (pos_v[a] < d[a]) break;
         pos_v[a] = 0;
         pos_o[a] = 0;
      end
   endfunction

   // driver: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) accumulate_voxel(req_voxel_bits);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (voxel_q.size() > 0) begin
               req_valid <= 1'b1;
               req_voxel_bits <= voxel_q.pop_front();
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor with its own stall pattern
   always @(posedge clock) begin
      cycles++;
      if (rsp_valid && rsp_ready) begin
         if (mean_q.size() == 0) begin
            $error("result beat with nothing expected: mean %h", rsp_mean_bits);
            errors++;
         end else begin
            block_mean_type e;
            e = mean_q.pop_front();
            if (rsp_mean_bits !== e.mean) begin
               $error("mean_bits expected %h actual %h", e.mean, rsp_mean_bits); errors++;
            end
            if (rsp_block_x !== e.bx) begin
               $error("block_x expected %0d actual %0d", e.bx, rsp_block_x); errors++;
            end
            if (rsp_block_y !== e.by) begin
               $error("block_y expected %0d actual %0d", e.by, rsp_block_y); errors++;
            end
            if (rsp_block_z !== e.bz) begin
               $error("block_z expected %0d actual %0d", e.bz, rsp_block_z); errors++;
            end
            if (rsp_cube_done !== e.done) begin
               $error("cube_done expected %0d actual %0d", e.done, rsp_cube_done); errors++;
            end
            if (rsp_store_overflow !== e.ovf) begin
               $error("store_overflow expected %0d actual %0d", e.ovf, rsp_store_overflow);
               errors++;
            end
         end
      end
      case (cycles[10:9])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= $urandom_range(0, 1);
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= cycles[5];
      endcase
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (voxel_q.size() != 0 || req_valid || mean_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_DIM_X: cfg_dim[0] = val;
         REG_DIM_Y: cfg_dim[1] = val;
         REG_DIM_Z: cfg_dim[2] = val;
         REG_FACTOR_X: cfg_fac[0] = val[4:0];
         REG_FACTOR_Y: cfg_fac[1] = val[4:0];
         REG_FACTOR_Z: cfg_fac[2] = val[4:0];
         default: ;
      endcase
      restart_cube();
   endtask

   task automatic set_cube(input int dx, input int dy, input int dz,
                           input int fx, input int fy, input int fz);
      wait_idle();
      write_reg(REG_DIM_X, CSR_DATA_W'(dx));
      write_reg(REG_DIM_Y, CSR_DATA_W'(dy));
      write_reg(REG_DIM_Z, CSR_DATA_W'(dz));
      write_reg(REG_FACTOR_X, CSR_DATA_W'(fx));
      write_reg(REG_FACTOR_Y, CSR_DATA_W'(fy));
      write_reg(REG_FACTOR_Z, CSR_DATA_W'(fz));
   endtask

   function automatic logic [31:0] random_voxel();
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
         3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
         4: return {$urandom_range(0, 1) == 1, 31'd0};
         5: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom())};
         6: return {$urandom_range(0, 1) == 1, 8'hFE, 23'($urandom())};
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)),
                          23'($urandom())};
      endcase
   endfunction

   task automatic add_voxel(input logic [31:0] v);
      voxel_q.push_back(v);
      pushed++;
   endtask

   initial begin
      int d[3], n;
      cfg_dim = '{1024, 1024, 1024};
      cfg_fac = '{2, 2, 2};
      restart_cube();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: no block completes
      add_voxel(32'h3F80_0000); add_voxel(QNAN_BITS); add_voxel(32'hFFFF_FFFF);
      add_voxel(32'h0000_0001); add_voxel(32'h7F7F_FFFF);

      // one 2x2 block per cube: empty, inf minus inf, overflow to inf, denormals
      set_cube(2, 2, 1, 2, 2, 2);
      add_voxel(32'h7F80_0001); add_voxel(QNAN_BITS); add_voxel(32'hFFC0_0000);
      add_voxel(32'h7FFF_FFFF);
      add_voxel(32'h7F80_0000); add_voxel(32'hFF80_0000); add_voxel(32'h3F80_0000);
      add_voxel(32'h4000_0000);
      add_voxel(32'h7F7F_FFFF); add_voxel(32'h7F7F_FFFF); add_voxel(QNAN_BITS);
      add_voxel(32'h7F7F_FFFF);
      add_voxel(32'h0000_0001); add_voxel(32'h8000_0003); add_voxel(32'h0000_0005);
      add_voxel(32'h807F_FFFF);

      // zero sizes act as one
      set_cube(0, 0, 0, 0, 0, 0);
      add_voxel(NEG_ZERO); add_voxel(32'h0000_0000); add_voxel(32'hC2F6_E979);

      // oversized dims and factors clamp
      set_cube(2047, 1, 1, 31, 0, 31);
      for (int i = 0; i < 48; i++) add_voxel(random_voxel());

      // plane of blocks larger than the store
      set_cube(2047, 5, 1, 1, 1, 1);
      for (int i = 0; i < 40; i++) add_voxel(random_voxel());

      while (pushed < VOXEL_GOAL) begin
         for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 11))
               0: d[a] = 0;
               1: d[a] = 2047;
               2: d[a] = 1024;
               3: d[a] = $urandom_range(0, 2047);
               default: d[a] = $urandom_range(1, 7);
            endcase
         end
         set_cube(d[0], d[1], d[2],
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 4),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 4),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 4));
         n = clamp_cfg(d[0], 1024) * clamp_cfg(d[1], 1024) * clamp_cfg(d[2], 1024);
         n = n * $urandom_range(1, 2) + $urandom_range(0, 5);
         if (n > 150) n = $urandom_range(60, 150);
         for (int i = 0; i < n; i++) add_voxel(random_voxel());
      end

      wait_idle();
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- nan_skipping_block_mean_downsample_unit.f -----
hdl/nsbmd_pkg.sv
hdl/nsbmd_ram.sv
hdl/nsbmd_ctrl.sv
hdl/nsbmd_dp.sv
hdl/nan_skipping_block_mean_downsample_unit.sv
tb/tb_nan_skipping_block_mean_downsample_unit.sv
